>>> hw/rtl/ssd_pkg.sv
`default_nettype none

package ssd_pkg;

   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned COUNT_BITS = 4;
   localparam int unsigned ADDR_BITS  = 24;

   typedef struct packed {
      logic                   first;
      logic [WORD_BITS-1:0]   data_word;
      logic [COUNT_BITS-1:0]  byte_count;
   } item_type;

   typedef struct packed {
      logic sweep_busy;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/ssd_if.sv
`default_nettype none

interface ssd_req_if;
   logic                            valid;
   logic                            ready;
   logic                            first;
   logic [ssd_pkg::WORD_BITS-1:0]   data_word;
   logic [ssd_pkg::COUNT_BITS-1:0]  byte_count;

   modport source (output valid, output first, output data_word, output byte_count,
                   input ready);
   modport sink (input valid, input first, input data_word, input byte_count,
                 output ready);
endinterface

interface ssd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ssd_pkg::ADDR_BITS-1:0]   dest_offset;
   logic [ssd_pkg::WORD_BITS-1:0]   out_word;
   logic [ssd_pkg::COUNT_BITS-1:0]  out_count;
   logic                            image_done;
   logic                            overrun;

   modport source (output valid, output dest_offset, output out_word, output out_count,
                   output image_done, output overrun, input ready);
   modport sink (input valid, input dest_offset, input out_word, input out_count,
                 input image_done, input overrun, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ssd_front.sv
`default_nettype none

module ssd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   ssd_req_if.sink                  req_chan,
   input  wire ssd_pkg::status_type status,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output ssd_pkg::item_type        push_item
);

   logic                hold_valid_ff;
   ssd_pkg::item_type   hold_item_ff;
   ssd_pkg::item_type   hold_item_in;
   logic                take;

   assign req_chan.ready = (!hold_valid_ff || push_ready) && !status.sweep_busy;
   assign take           = req_chan.valid && req_chan.ready;
   assign push_valid     = hold_valid_ff;
   assign push_item      = hold_item_ff;

   // byte counts outside one to eight mean a full word
   always_comb begin
      hold_item_in.first     = req_chan.first;
      hold_item_in.data_word = req_chan.data_word;
      if (req_chan.byte_count == 4'd0 || req_chan.byte_count > 4'd8) begin
         hold_item_in.byte_count = 4'd8;
      end else begin
         hold_item_in.byte_count = req_chan.byte_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (take) begin
         hold_valid_ff <= 1'b1;
      end else if (push_ready) begin
         hold_valid_ff <= 1'b0;
      end
      if (take) begin
         hold_item_ff <= hold_item_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ssd_queue.sv
`default_nettype none

module ssd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire ssd_pkg::item_type push_item,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output ssd_pkg::item_type      pop_item
);

   ssd_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ssd_back.sv
`default_nettype none

module ssd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [23:0]       image_size,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire ssd_pkg::item_type pop_item,
   ssd_rsp_if.source              rsp_chan,
   output ssd_pkg::status_type    status
);

   localparam int unsigned TAG_BITS   = 12;
   localparam int unsigned IDX_BITS   = 16;
   localparam int unsigned CHUNK_BITS = 22;
   localparam logic [CHUNK_BITS-1:0] CHUNK_FULL = 22'h200000;
   localparam logic [TAG_BITS-1:0]   TAG_LAST   = '1;
   localparam logic [14:0] RNG_MUL    = 15'd2109;
   localparam logic [14:0] RNG_INC    = 15'd9273;
   localparam logic [15:0] RNG_OFFSET = 16'hc000;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic [IDX_BITS-1:0] val;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_HALVE, S_SLICE, S_MUL, S_RDX, S_WRI, S_WRX,
      S_DEST, S_EMIT
   } state_type;

   entry_type slice_mem [2**IDX_BITS];
   entry_type rd_data_ff;

   state_type             state_ff;
   logic [IDX_BITS-1:0]   clr_addr_ff;
   logic                  resume_ff;
   logic [TAG_BITS-1:0]   epoch_ff;

   logic [63:0]           word_ff;
   logic [3:0]            cnt_ff;
   logic [14:0]           seed_ff;
   logic [23:0]           bytes_left_ff;
   logic [CHUNK_BITS-1:0] chunk_ff;
   logic [23:0]           base_ff;
   logic [IDX_BITS:0]     countdown_ff;
   logic [IDX_BITS-1:0]   cur_dest_ff;
   logic [1:0]            wis_ff;
   logic [31:0]           prod_ff;
   logic [IDX_BITS-1:0]   vi_ff;

   logic [23:0]           res_dest_ff;
   logic [63:0]           res_word_ff;
   logic [3:0]            res_count_ff;
   logic                  res_done_ff;
   logic                  res_overrun_ff;

   logic                  out_valid_ff;
   logic [23:0]           out_dest_ff;
   logic [63:0]           out_word_ff;
   logic [3:0]            out_count_ff;
   logic                  out_done_ff;
   logic                  out_overrun_ff;

   logic [IDX_BITS-1:0]   i_idx;
   logic [IDX_BITS-1:0]   x_idx;
   logic                  tail;
   logic                  chunk_big;
   logic [IDX_BITS-1:0]   rd_val;
   logic [IDX_BITS-1:0]   vi;
   logic [IDX_BITS-1:0]   vx;
   logic [14:0]           seed_step;
   logic [15:0]           rnd;
   logic [1:0]            wis_next;
   logic [3:0]            take;
   logic [23:0]           left_next;
   logic [23:0]           dest;
   logic                  slot_free;

   logic                  mem_wr_en;
   logic [IDX_BITS-1:0]   mem_wr_addr;
   entry_type             mem_wr_data;
   logic                  mem_rd_en;
   logic [IDX_BITS-1:0]   mem_rd_addr;

   assign i_idx     = IDX_BITS'(countdown_ff - 17'd1);
   assign x_idx     = prod_ff[31:16];
   assign chunk_big = |chunk_ff[CHUNK_BITS-1:5];
   assign tail      = !chunk_big;
   assign rd_val    = rd_data_ff.val;
   assign vi        = (rd_data_ff.tag == epoch_ff) ? rd_val : i_idx;
   assign vx        = (rd_data_ff.tag == epoch_ff) ? rd_val : x_idx;
   assign seed_step = 15'(seed_ff * RNG_MUL + RNG_INC);
   assign rnd       = 16'({1'b0, seed_ff} + RNG_OFFSET);
   assign wis_next  = wis_ff + 2'd1;
   assign take      = (bytes_left_ff < 24'd8) ? bytes_left_ff[3:0] : 4'd8;
   assign left_next = bytes_left_ff - 24'(take);
   assign slot_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      if (tail) begin
         dest = 24'(base_ff + 24'({wis_ff, 3'b000}));
      end else begin
         dest = 24'(base_ff + 24'({cur_dest_ff, 5'b00000}) + 24'({wis_ff, 3'b000}));
      end
   end

   assign pop_ready         = (state_ff == S_IDLE);
   assign status.sweep_busy = (state_ff == S_CLEAR);

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.dest_offset = out_dest_ff;
   assign rsp_chan.out_word    = out_word_ff;
   assign rsp_chan.out_count   = out_count_ff;
   assign rsp_chan.image_done  = out_done_ff;
   assign rsp_chan.overrun     = out_overrun_ff;

   // table port control
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = i_idx;
      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         S_SLICE: begin
            mem_rd_en = !tail && (wis_ff == 2'd0);
         end
         S_RDX: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = x_idx;
         end
         S_WRI: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = i_idx;
            mem_wr_data = '{tag: epoch_ff, val: vx};
         end
         S_WRX: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = x_idx;
            mem_wr_data = '{tag: epoch_ff, val: vi_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         slice_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= slice_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         resume_ff     <= 1'b0;
         epoch_ff      <= '0;
         seed_ff       <= '0;
         bytes_left_ff <= '0;
         chunk_ff      <= CHUNK_FULL;
         base_ff       <= '0;
         countdown_ff  <= '0;
         cur_dest_ff   <= '0;
         wis_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (state_ff == S_EMIT && slot_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + IDX_BITS'(1);
               if (&clr_addr_ff) begin
                  epoch_ff <= TAG_BITS'(1);
                  state_ff <= resume_ff ? S_SLICE : S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop_valid) begin
                  word_ff <= pop_item.data_word;
                  cnt_ff  <= pop_item.byte_count;
                  if (pop_item.first) begin
                     seed_ff       <= image_size[14:0];
                     bytes_left_ff <= image_size;
                     chunk_ff      <= CHUNK_FULL;
                     base_ff       <= '0;
                     countdown_ff  <= '0;
                     cur_dest_ff   <= '0;
                     wis_ff        <= '0;
                  end
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (bytes_left_ff == 24'd0) begin
                  res_dest_ff    <= '0;
                  res_word_ff    <= '0;
                  res_count_ff   <= '0;
                  res_done_ff    <= 1'b0;
                  res_overrun_ff <= 1'b1;
                  state_ff       <= S_EMIT;
               end else if (wis_ff == 2'd0 && countdown_ff == '0 && chunk_big) begin
                  state_ff <= S_HALVE;
               end else begin
                  state_ff <= S_SLICE;
               end
            end
            S_HALVE: begin
               if (chunk_big && bytes_left_ff < 24'(chunk_ff)) begin
                  chunk_ff <= chunk_ff >> 1;
               end else if (chunk_big) begin
                  countdown_ff <= 17'(chunk_ff >> 5);
                  if (epoch_ff == TAG_LAST) begin
                     resume_ff   <= 1'b1;
                     clr_addr_ff <= '0;
                     state_ff    <= S_CLEAR;
                  end else begin
                     epoch_ff <= epoch_ff + TAG_BITS'(1);
                     state_ff <= S_SLICE;
                  end
               end else begin
                  state_ff <= S_SLICE;
               end
            end
            S_SLICE: begin
               if (!tail && wis_ff == 2'd0) begin
                  seed_ff  <= seed_step;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_DEST;
               end
            end
            S_MUL: begin
               vi_ff    <= vi;
               prod_ff  <= 32'(rnd) * 32'(i_idx);
               state_ff <= S_RDX;
            end
            S_RDX: begin
               state_ff <= S_WRI;
            end
            S_WRI: begin
               cur_dest_ff  <= vx;
               countdown_ff <= {1'b0, i_idx};
               state_ff     <= S_WRX;
            end
            S_WRX: begin
               state_ff <= S_DEST;
            end
            S_DEST: begin
               wis_ff <= wis_next;
               if (!tail && wis_next == 2'd0 && countdown_ff == '0) begin
                  base_ff <= 24'(base_ff + 24'(chunk_ff));
               end
               bytes_left_ff  <= left_next;
               res_dest_ff    <= dest;
               res_word_ff    <= word_ff;
               res_count_ff   <= (cnt_ff < take) ? cnt_ff : take;
               res_done_ff    <= (left_next == 24'd0);
               res_overrun_ff <= 1'b0;
               state_ff       <= S_EMIT;
            end
            S_EMIT: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (state_ff == S_EMIT && slot_free) begin
         out_dest_ff    <= res_dest_ff;
         out_word_ff    <= res_word_ff;
         out_count_ff   <= res_count_ff;
         out_done_ff    <= res_done_ff;
         out_overrun_ff <= res_overrun_ff;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/slice_shuffle_descrambler_top.sv
// slice shuffle descrambler
// req_chan carries source words of a scrambled image (first, data_word,
// byte_count); rsp_chan returns one result per word with its destination
// byte offset, the word unchanged (zero on overrun), its valid byte count, image_done and
// overrun. a transfer happens on each edge with valid and ready high.
// csr_wr_en / csr_wr_data write image_size; it is sampled on a word with
// first set and must only be written while the block is idle.
// each word passes the back-end states idle, check, slice, dest and emit, an
// overrun word skipping slice and dest; a word that opens a slice adds the
// generator step and index multiply (mul), the table read (rdx) and the swap
// writes (wri, wrx); a chunk start adds a halve state, repeated per halving.
// a result passes the front register, the queue, these back-end states and
// the output register.
// after reset all 65536 table entries are cleared with req_chan.ready low;
// the same sweep repeats once every 4095 chunk starts.
// a front register and a two-deep queue keep taking words while a result
// waits on a stalled receiver; the result holds until its transfer.
`default_nettype none

module slice_shuffle_descrambler_top (
   input  wire logic        clock,
   input  wire logic        reset,
   ssd_req_if.sink          req_chan,
   ssd_rsp_if.source        rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [23:0] csr_wr_data
);

   logic [23:0]         image_size_ff;
   ssd_pkg::status_type status;
   logic                push_valid;
   logic                push_ready;
   ssd_pkg::item_type   push_item;
   logic                pop_valid;
   logic                pop_ready;
   ssd_pkg::item_type   pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= '0;
      end else if (csr_wr_en) begin
         image_size_ff <= csr_wr_data;
      end
   end

   ssd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .status     (status),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   ssd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   ssd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .image_size (image_size_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_chan   (rsp_chan),
      .status     (status)
   );

endmodule

`default_nettype wire
